@@ hw/rtl/best_fit_segment_allocator_defines.svh @@
// Assertion macros shared by the segment allocator RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// Condition that must hold at every rising clock edge outside reset.
`define BFSA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bfsa_pkg.sv @@
// Shared types and constants for the best-fit segment allocator.
// No dependencies.
package bfsa_pkg;

    localparam int ID_FIELD_W   = 16;
    localparam int SIZE_FIELD_W = 40;

    // Disk size after reset, in kilobytes.
    localparam logic [63:0] DISK_RESET = 64'd1048576;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_COMPACT = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_PLACED     = 3'd0,
        STAT_COMPACTED  = 3'd1,
        STAT_DISK_FULL  = 3'd2,
        STAT_TABLE_FULL = 3'd3,
        STAT_NOT_FOUND  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FIT,
        S_FIT_END,
        S_SHIFT,
        S_SPLIT_TAIL,
        S_SPLIT_HEAD,
        S_COMPACT,
        S_COMPACT_END,
        S_FIND,
        S_TIDY,
        S_TIDY_END,
        S_CLEAR,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        func_t                   func;
        logic [ID_FIELD_W-1:0]   file_id;
        logic [SIZE_FIELD_W-1:0] file_size;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [SIZE_FIELD_W-1:0] start_address;
        logic                    error_sticky;
    } resp_t;

endpackage

@@ hw/rtl/bfsa_table.sv @@
// Segment table storage: one write port, one registered read port.
// No dependencies.
module bfsa_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 97,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read first: a read of the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/bfsa_ctrl.sv @@
// Sequencer and shared datapath of the segment allocator.
// Depends on bfsa_pkg and best_fit_segment_allocator_defines.svh.
`include "best_fit_segment_allocator_defines.svh"

module bfsa_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    parameter int SIZE_BITS    = 40,
    parameter int ID_BITS      = 16,
    parameter int IDX_W        = $clog2(MAX_SEGMENTS),
    parameter int ENT_W        = 1 + ID_BITS + 2 * SIZE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bfsa_pkg::req_t       req,
    input  logic [SIZE_BITS-1:0] disk_size,
    output logic                 resp_valid,
    input  logic                 resp_ready,
    output bfsa_pkg::resp_t      resp,
    output logic [IDX_W-1:0]     rd_addr,
    input  logic [ENT_W-1:0]     rd_data,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output logic [ENT_W-1:0]     wr_data
);
    import bfsa_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int START_L = SIZE_BITS;
    localparam int OWNER_L = 2 * SIZE_BITS;
    localparam int FREE_B  = 2 * SIZE_BITS + ID_BITS;
    localparam logic [SIZE_BITS-1:0] RST_DISK = SIZE_BITS'(DISK_RESET);
    localparam logic [CNT_W-1:0] RST_CNT = (RST_DISK != '0) ? CNT_W'(1) : CNT_W'(0);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    seq_state_t           state_reg, state_next;
    func_t                func_reg, func_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 full_reg, full_next;
    logic [CNT_W-1:0]     r_reg, r_next;
    logic [CNT_W-1:0]     w_reg, w_next;
    logic [IDX_W-1:0]     d_reg, d_next;
    logic                 dv_reg, dv_next;
    logic                 after_reg, after_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_len_reg, best_len_next;
    logic [SIZE_BITS-1:0] best_start_reg, best_start_next;
    logic [SIZE_BITS-1:0] pos_reg, pos_next;
    logic [SIZE_BITS-1:0] ftot_reg, ftot_next;
    logic [ENT_W-1:0]     pend_reg, pend_next;
    logic                 pv_reg, pv_next;
    status_t              res_status_reg, res_status_next;
    logic [SIZE_BITS-1:0] res_addr_reg, res_addr_next;

    // Fields of the entry read last cycle.
    logic                 c_free;
    logic [ID_BITS-1:0]   c_owner;
    logic [SIZE_BITS-1:0] c_start;
    logic [SIZE_BITS-1:0] c_len;
    logic                 cur_free;
    logic [ENT_W-1:0]     cur_ent;

    // The one shared adder.
    logic [SIZE_BITS-1:0] add_a, add_b, add_sum;

    logic fwd_done;
    logic ok_status_sel;

    assign c_len   = rd_data[SIZE_BITS-1:0];
    assign c_start = rd_data[START_L +: SIZE_BITS];
    assign c_owner = rd_data[OWNER_L +: ID_BITS];
    assign c_free  = rd_data[FREE_B];

    // During the tidy pass the removed entry reads as free.
    always_comb
    begin
        if (found_reg && (d_reg == best_idx_reg) && (state_reg == S_TIDY))
        begin
            cur_free = 1'b1;
            cur_ent  = {1'b1, {ID_BITS{1'b0}}, c_start, c_len};
        end
        else
        begin
            cur_free = c_free;
            cur_ent  = rd_data;
        end
    end

    assign add_sum  = add_a + add_b;
    assign fwd_done = !dv_reg && (r_reg >= count_reg);
    assign ok_status_sel = after_reg;

    assign resp.status        = res_status_reg;
    assign resp.start_address = SIZE_FIELD_W'(res_addr_reg);
    assign resp.error_sticky  = full_reg;

    // Next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        full_next       = full_reg;
        r_next          = r_reg;
        w_next          = w_reg;
        d_next          = d_reg;
        dv_next         = 1'b0;
        after_next      = after_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        pos_next        = pos_reg;
        ftot_next       = ftot_reg;
        pend_next       = pend_reg;
        pv_next         = pv_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        add_a           = pos_reg;
        add_b           = c_len;
        rd_addr         = r_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = w_reg[IDX_W-1:0];
        wr_data         = '0;
        req_ready       = 1'b0;
        resp_valid      = 1'b0;

        // Forward scans issue one read per cycle.
        if ((state_reg == S_FIT || state_reg == S_COMPACT || state_reg == S_FIND ||
             state_reg == S_TIDY) && (r_reg < count_reg))
        begin
            dv_next = 1'b1;
            d_next  = r_reg[IDX_W-1:0];
            r_next  = r_reg + 1'b1;
        end

        case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {1'b1, {ID_BITS{1'b0}}, {SIZE_BITS{1'b0}}, RST_DISK};
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    func_next       = req.func;
                    id_next         = ID_BITS'(req.file_id);
                    size_next       = SIZE_BITS'(req.file_size);
                    r_next          = '0;
                    w_next          = '0;
                    pos_next        = '0;
                    ftot_next       = '0;
                    found_next      = 1'b0;
                    pv_next         = 1'b0;
                    after_next      = 1'b0;
                    res_status_next = STAT_PLACED;
                    res_addr_next   = '0;
                    case (req.func)
                        FUNC_INSERT:  state_next = S_FIT;
                        FUNC_REMOVE:  state_next = S_FIND;
                        FUNC_COMPACT: state_next = S_COMPACT;
                        FUNC_CLEAR:   state_next = S_CLEAR;
                        default:      state_next = S_CLEAR;
                    endcase
                end
            end

            // Best-fit search: smallest free segment that holds the file.
            S_FIT:
            begin
                if (dv_reg && c_free && (c_len >= size_reg) &&
                    (!found_reg || (c_len < best_len_reg)))
                begin
                    found_next      = 1'b1;
                    best_idx_next   = d_reg;
                    best_len_next   = c_len;
                    best_start_next = c_start;
                end
                if (fwd_done)
                begin
                    state_next = S_FIT_END;
                end
            end

            S_FIT_END:
            begin
                res_status_next = ok_status_sel ? STAT_COMPACTED : STAT_PLACED;
                if (found_reg)
                begin
                    res_addr_next = best_start_reg;
                    if (size_reg == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else if (best_len_reg == size_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = best_idx_reg;
                        wr_data    = {1'b0, id_reg, best_start_reg, best_len_reg};
                        state_next = S_RESP;
                    end
                    else if (count_reg >= MAX_CNT)
                    begin
                        res_status_next = STAT_TABLE_FULL;
                        res_addr_next   = '0;
                        full_next       = 1'b1;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        r_next     = count_reg - 1'b1;
                        state_next = S_SHIFT;
                    end
                end
                else if (!after_reg)
                begin
                    r_next     = '0;
                    w_next     = '0;
                    pos_next   = '0;
                    ftot_next  = '0;
                    state_next = S_COMPACT;
                end
                else
                begin
                    res_status_next = STAT_DISK_FULL;
                    full_next       = 1'b1;
                    state_next      = S_RESP;
                end
            end

            // Move entries above the split point up by one, top first.
            S_SHIFT:
            begin
                if (r_reg > CNT_W'(best_idx_reg))
                begin
                    dv_next = 1'b1;
                    d_next  = r_reg[IDX_W-1:0];
                    r_next  = r_reg - 1'b1;
                end
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = d_reg + 1'b1;
                    wr_data = rd_data;
                end
                if (!dv_reg && !(r_reg > CNT_W'(best_idx_reg)))
                begin
                    state_next = S_SPLIT_TAIL;
                end
            end

            S_SPLIT_TAIL:
            begin
                add_a      = best_start_reg;
                add_b      = size_reg;
                wr_en      = 1'b1;
                wr_addr    = best_idx_reg + 1'b1;
                wr_data    = {1'b1, {ID_BITS{1'b0}}, add_sum, best_len_reg - size_reg};
                state_next = S_SPLIT_HEAD;
            end

            S_SPLIT_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = best_idx_reg;
                wr_data    = {1'b0, id_reg, best_start_reg, size_reg};
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end

            // Pack files to the front and total the free space.
            S_COMPACT:
            begin
                if (dv_reg)
                begin
                    if (c_free)
                    begin
                        add_a     = ftot_reg;
                        ftot_next = add_sum;
                    end
                    else if (c_len != '0)
                    begin
                        add_a    = pos_reg;
                        wr_en    = 1'b1;
                        wr_data  = {1'b0, c_owner, pos_reg, c_len};
                        pos_next = add_sum;
                        w_next   = w_reg + 1'b1;
                    end
                end
                if (fwd_done)
                begin
                    state_next = S_COMPACT_END;
                end
            end

            S_COMPACT_END:
            begin
                if ((ftot_reg != '0) && (w_reg < MAX_CNT))
                begin
                    wr_en      = 1'b1;
                    wr_data    = {1'b1, {ID_BITS{1'b0}}, pos_reg, ftot_reg};
                    count_next = w_reg + 1'b1;
                end
                else
                begin
                    count_next = w_reg;
                end
                if (func_reg == FUNC_INSERT)
                begin
                    after_next = 1'b1;
                    found_next = 1'b0;
                    r_next     = '0;
                    state_next = S_FIT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // Find the first allocated segment with the given id.
            S_FIND:
            begin
                if (dv_reg && !found_reg && !c_free && (c_owner == id_reg))
                begin
                    found_next    = 1'b1;
                    best_idx_next = d_reg;
                end
                if (fwd_done)
                begin
                    if (found_reg)
                    begin
                        r_next     = '0;
                        w_next     = '0;
                        pv_next    = 1'b0;
                        state_next = S_TIDY;
                    end
                    else
                    begin
                        res_status_next = STAT_NOT_FOUND;
                        state_next      = S_RESP;
                    end
                end
            end

            // Drop empty entries and merge neighboring free segments.
            S_TIDY:
            begin
                if (dv_reg && (c_len != '0))
                begin
                    if (pv_reg && pend_reg[FREE_B] && cur_free)
                    begin
                        add_a                      = pend_reg[SIZE_BITS-1:0];
                        pend_next[SIZE_BITS-1:0]   = add_sum;
                    end
                    else
                    begin
                        if (pv_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_data = pend_reg;
                            w_next  = w_reg + 1'b1;
                        end
                        pend_next = cur_ent;
                        pv_next   = 1'b1;
                    end
                end
                if (fwd_done)
                begin
                    state_next = S_TIDY_END;
                end
            end

            S_TIDY_END:
            begin
                if (pv_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = pend_reg;
                    count_next = w_reg + 1'b1;
                end
                else
                begin
                    count_next = w_reg;
                end
                state_next = S_RESP;
            end

            S_CLEAR:
            begin
                full_next = 1'b0;
                if (disk_size == '0)
                begin
                    count_next = '0;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = {1'b1, {ID_BITS{1'b0}}, {SIZE_BITS{1'b0}}, disk_size};
                    count_next = CNT_W'(1);
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                resp_valid = 1'b1;
                if (resp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= RST_CNT;
            full_reg  <= 1'b0;
            dv_reg    <= 1'b0;
            found_reg <= 1'b0;
            pv_reg    <= 1'b0;
            after_reg <= 1'b0;
            r_reg     <= '0;
            w_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            full_reg  <= full_next;
            dv_reg    <= dv_next;
            found_reg <= found_next;
            pv_reg    <= pv_next;
            after_reg <= after_next;
            r_reg     <= r_next;
            w_reg     <= w_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        id_reg         <= id_next;
        size_reg       <= size_next;
        d_reg          <= d_next;
        best_idx_reg   <= best_idx_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        pos_reg        <= pos_next;
        ftot_reg       <= ftot_next;
        pend_reg       <= pend_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
    end

    `BFSA_ASSERT(a_count_bound, count_reg <= MAX_CNT, "segment count above table depth")
    `BFSA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, state_reg != S_IDLE, "idle after accepting a beat")
    `BFSA_ASSERT(a_fail_sticky, !resp_valid || (res_status_reg != STAT_DISK_FULL && res_status_reg != STAT_TABLE_FULL) || full_reg, "failed insert without error flag")
    `BFSA_ASSERT_NEXT(a_split_grows, state_reg == S_SPLIT_HEAD, count_reg == $past(count_reg) + 1'b1, "split did not add a segment")

endmodule

@@ hw/rtl/best_fit_segment_allocator.sv @@
// Best-fit segment allocator: a table of MAX_SEGMENTS disk segments managed
// by one sequencer that walks the table one entry per cycle through a single
// read and write port and one shared adder. An insert scans the table for a
// fit; when none exists it compacts and scans again, and to split a segment
// it shifts the entries above it up by one. After reset the block writes the
// first segment before it takes a beat. A result waits in an output register
// while the next beat is accepted. Configuration beats are taken at any time.
module best_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int SIZE_BITS    = 40,
    parameter int ID_BITS      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: file_id[15:0], file_size[55:16]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // tuser: func[1:0]
    input  logic [1:0]  s_tuser,
    // tdata: start_address[39:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // tuser: status[2:0], error_sticky[3]
    output logic [3:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [39:0] cfg_data
);
    import bfsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int ENT_W = 1 + ID_BITS + 2 * SIZE_BITS;

    logic [SIZE_BITS-1:0] disk_size_reg;
    req_t                 req;
    resp_t                resp;
    logic                 resp_valid, resp_ready;
    logic                 m_tvalid_reg;
    resp_t                m_resp_reg;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [ENT_W-1:0]     rd_data, wr_data;
    logic                 wr_en;

    // Disk size register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_size_reg <= SIZE_BITS'(DISK_RESET);
        end
        else if (cfg_valid)
        begin
            disk_size_reg <= SIZE_BITS'(cfg_data);
        end
    end

    // Unpack the input beat.
    assign req.func      = func_t'(s_tuser);
    assign req.file_id   = s_tdata[15:0];
    assign req.file_size = s_tdata[55:16];

    // Output register.
    assign resp_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (resp_ready)
        begin
            m_tvalid_reg <= resp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_ready && resp_valid)
        begin
            m_resp_reg <= resp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_resp_reg.start_address;
    assign m_tuser  = {m_resp_reg.error_sticky, m_resp_reg.status};

    bfsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SIZE_BITS    (SIZE_BITS),
        .ID_BITS      (ID_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .disk_size  (disk_size_reg),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    bfsa_table #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (ENT_W)
    ) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

@@ tb/best_fit_segment_allocator_tb.sv @@
// Self-checking testbench for the best-fit segment allocator.
// Depends on bfsa_pkg and best_fit_segment_allocator; it keeps its own model of the
// segment table and checks every result beat against it.
`timescale 1ns / 100ps

module best_fit_segment_allocator_tb;
    import bfsa_pkg::*;

    localparam int SEGS = 64;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE = 320;

    typedef struct {
        func_t       op;
        logic [15:0] id;
        logic [39:0] size;
        bit          wait_drain;
    } cmd_t;

    typedef struct {
        status_t     status;
        logic [39:0] addr;
        logic        sticky;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [39:0] cfg_data;

    cmd_t     cmd_queue[$];
    outcome_t predicted_results[$];

    // Shadow of the segment table.
    bit          tbl_free[SEGS];
    logic [15:0] tbl_owner[SEGS];
    logic [39:0] tbl_start[SEGS];
    logic [39:0] tbl_len[SEGS];
    int          tbl_count;
    bit          tbl_full_flag;
    logic [39:0] disk_capacity;

    int  error_count;
    int  idle_cycles;
    bit  throttle;
    bit  long_hold_req;
    bit  in_took;
    bit  out_took;
    bit  cfg_took;
    int  send_gap;
    int  recv_hold;

    best_fit_segment_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Free-running clock.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Table model operations.
    function automatic void table_clear();
        for (int i = 0; i < SEGS; i++)
        begin
            tbl_free[i] = 0;
            tbl_owner[i] = '0;
            tbl_start[i] = '0;
            tbl_len[i] = '0;
        end
        tbl_full_flag = 0;
        if (disk_capacity == 0)
        begin
            tbl_count = 0;
        end
        else
        begin
            tbl_count = 1;
            tbl_free[0] = 1;
            tbl_len[0] = disk_capacity;
        end
    endfunction

    function automatic void move_entry(int dst, int src);
        tbl_free[dst] = tbl_free[src];
        tbl_owner[dst] = tbl_owner[src];
        tbl_start[dst] = tbl_start[src];
        tbl_len[dst] = tbl_len[src];
    endfunction

    // Drop empty entries and merge neighboring free ones.
    function automatic void merge_free();
        int w;
        w = 0;
        for (int r = 0; r < tbl_count; r++)
        begin
            if (tbl_len[r] == 0)
                continue;
            if (w > 0 && tbl_free[w-1] && tbl_free[r])
            begin
                tbl_len[w-1] = tbl_len[w-1] + tbl_len[r];
                continue;
            end
            if (w != r)
                move_entry(w, r);
            w++;
        end
        tbl_count = w;
    endfunction

    // Pack files to the front; free space, if any and if room remains, becomes one segment at the end.
    function automatic void pack_files();
        int          w;
        logic [39:0] pos;
        logic [39:0] free_sum;
        w = 0;
        pos = '0;
        free_sum = '0;
        for (int r = 0; r < tbl_count; r++)
        begin
            if (tbl_free[r])
            begin
                free_sum = free_sum + tbl_len[r];
                continue;
            end
            if (tbl_len[r] == 0)
                continue;
            if (w != r)
                move_entry(w, r);
            tbl_start[w] = pos;
            pos = pos + tbl_len[w];
            w++;
        end
        if (free_sum != 0 && w < SEGS)
        begin
            tbl_free[w] = 1;
            tbl_owner[w] = '0;
            tbl_start[w] = pos;
            tbl_len[w] = free_sum;
            w++;
        end
        tbl_count = w;
    endfunction

    function automatic int smallest_fit(logic [39:0] size);
        int best;
        best = -1;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_free[i] && tbl_len[i] >= size && (best < 0 || tbl_len[i] < tbl_len[best]))
                best = i;
        end
        return best;
    endfunction

    // Returns 1 when the split would overflow the table.
    function automatic bit carve(logic [15:0] id, logic [39:0] size, int k,
                                 output logic [39:0] addr);
        addr = tbl_start[k];
        if (size == 0)
            return 0;
        if (tbl_len[k] == size)
        begin
            tbl_free[k] = 0;
            tbl_owner[k] = id;
            return 0;
        end
        if (tbl_count >= SEGS)
            return 1;
        for (int i = tbl_count; i > k + 1; i--)
            move_entry(i, i - 1);
        tbl_free[k+1] = 1;
        tbl_owner[k+1] = '0;
        tbl_start[k+1] = tbl_start[k] + size;
        tbl_len[k+1] = tbl_len[k] - size;
        tbl_free[k] = 0;
        tbl_owner[k] = id;
        tbl_len[k] = size;
        tbl_count++;
        return 0;
    endfunction

    function automatic outcome_t apply_command(cmd_t c);
        outcome_t    res;
        int          k;
        logic [39:0] addr;
        res.status = STAT_PLACED;
        res.addr = '0;
        case (c.op)
            FUNC_INSERT:
            begin
                k = smallest_fit(c.size);
                if (k < 0)
                begin
                    pack_files();
                    k = smallest_fit(c.size);
                    res.status = (k < 0) ? STAT_DISK_FULL : STAT_COMPACTED;
                end
                if (k >= 0)
                begin
                    if (carve(c.id, c.size, k, addr))
                        res.status = STAT_TABLE_FULL;
                    else
                        res.addr = addr;
                end
                if (res.status == STAT_DISK_FULL || res.status == STAT_TABLE_FULL)
                    tbl_full_flag = 1;
            end
            FUNC_REMOVE:
            begin
                res.status = STAT_NOT_FOUND;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (!tbl_free[i] && tbl_owner[i] == c.id)
                    begin
                        tbl_free[i] = 1;
                        tbl_owner[i] = '0;
                        merge_free();
                        res.status = STAT_PLACED;
                        break;
                    end
                end
            end
            FUNC_COMPACT:
                pack_files();
            default:
                table_clear();
        endcase
        res.sticky = tbl_full_flag;
        return res;
    endfunction

    // Monitor: checks result beats and predicts from accepted input beats.
    always @(posedge clk)
    begin
        outcome_t want;
        cmd_t     got_cmd;
        in_took <= s_tvalid && s_tready;
        out_took <= m_tvalid && m_tready;
        cfg_took <= cfg_valid && cfg_ready;
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (cfg_valid && cfg_ready)
                disk_capacity = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (m_tuser[2:0] !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_tuser[2:0]);
                        error_count++;
                    end
                    if (m_tdata !== want.addr)
                    begin
                        $display("%0t: start_address mismatch: expected %h, actual %h",
                                 $time, want.addr, m_tdata);
                        error_count++;
                    end
                    if (m_tuser[3] !== want.sticky)
                    begin
                        $display("%0t: error_sticky mismatch: expected %0d, actual %0d",
                                 $time, want.sticky, m_tuser[3]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                got_cmd.op = func_t'(s_tuser);
                got_cmd.id = s_tdata[15:0];
                got_cmd.size = s_tdata[55:16];
                got_cmd.wait_drain = 0;
                predicted_results.insert(predicted_results.size(), apply_command(got_cmd));
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("best_fit_segment_allocator_tb: FAIL");
                $finish;
            end
        end
    end

    // Driver: offers queued commands with random gaps.
    always @(negedge clk)
    begin
        logic        nxt_valid;
        logic [55:0] nxt_data;
        logic [1:0]  nxt_user;
        cmd_t        c;
        nxt_valid = s_tvalid;
        nxt_data = s_tdata;
        nxt_user = s_tuser;
        if (s_tvalid && in_took)
        begin
            void'(cmd_queue.pop_front());
            nxt_valid = 0;
            send_gap = throttle ? $urandom_range(0, 4) : 0;
        end
        if (!nxt_valid && rst_n)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (cmd_queue.size() > 0)
            begin
                c = cmd_queue[0];
                if (!c.wait_drain || predicted_results.size() == 0)
                begin
                    nxt_valid = 1;
                    nxt_data = {c.size, c.id};
                    nxt_user = c.op;
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata <= nxt_data;
        s_tuser <= nxt_user;
    end

    // Receiver: random stalls, plus one long hold when requested.
    always @(negedge clk)
    begin
        if (out_took)
            recv_hold = throttle ? $urandom_range(0, 4) : 0;
        if (long_hold_req)
        begin
            long_hold_req = 0;
            recv_hold = LONG_HOLD;
        end
        if (recv_hold > 0)
        begin
            recv_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_disk_size(input logic [39:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(input func_t op, input logic [15:0] id, input logic [39:0] size,
                            input bit wait_drain = 0);
        cmd_t c;
        c.op = op;
        c.id = id;
        c.size = size;
        c.wait_drain = wait_drain;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || predicted_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Random command with sizes scaled to the current disk.
    task automatic push_random_cmd(input logic [39:0] cap);
        int          r;
        logic [15:0] id;
        logic [39:0] size;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
        if ($urandom_range(0, 19) == 0)
            size = {8'($urandom), 32'($urandom)};
        else
            size = 40'($urandom_range(0, 15)) * (cap / 40 + 1) / 8 + 40'($urandom_range(0, 3));
        if (r < 50)
            push_cmd(FUNC_INSERT, id, size);
        else if (r < 88)
            push_cmd(FUNC_REMOVE, id, '0);
        else if (r < 97)
            push_cmd(FUNC_COMPACT, id, size);
        else
            push_cmd(FUNC_CLEAR, id, size);
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [39:0] caps[6];
        logic [39:0] cap;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        throttle = 1;
        long_hold_req = 0;
        send_gap = 0;
        recv_hold = 0;
        in_took = 0;
        out_took = 0;
        cfg_took = 0;
        disk_capacity = DISK_RESET[39:0];
        table_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed checks on the reset-size disk.
        push_cmd(FUNC_INSERT, 16'h0000, 40'd0);
        push_cmd(FUNC_REMOVE, 16'h0000, 40'd0);
        push_cmd(FUNC_INSERT, 16'hFFFF, 40'd1000);
        push_cmd(FUNC_INSERT, 16'h0001, 40'd2000);
        push_cmd(FUNC_INSERT, 16'h0002, 40'd500);
        push_cmd(FUNC_REMOVE, 16'h0001, '0);
        push_cmd(FUNC_INSERT, 16'h0003, 40'd2000);
        push_cmd(FUNC_REMOVE, 16'h1234, '0);
        push_cmd(FUNC_REMOVE, 16'hFFFF, '0);
        push_cmd(FUNC_INSERT, 16'h0004, 40'd1047000);
        push_cmd(FUNC_INSERT, 16'h0005, 40'hFF_FFFF_FFFF);
        push_cmd(FUNC_COMPACT, '0, '0);
        push_cmd(FUNC_CLEAR, '0, '0, 1);
        push_cmd(FUNC_INSERT, 16'h0006, 40'd1048576);
        push_cmd(FUNC_INSERT, 16'h0007, 40'd0);
        wait_idle();

        // Small disk filled with unit files until the table overflows.
        write_disk_size(40'd1000);
        push_cmd(FUNC_CLEAR, '0, '0);
        for (int i = 0; i < 66; i++)
            push_cmd(FUNC_INSERT, 16'(i + 1), 40'd1);
        push_cmd(FUNC_REMOVE, 16'd10, '0);
        push_cmd(FUNC_REMOVE, 16'd12, '0);
        push_cmd(FUNC_INSERT, 16'd99, 40'd3);
        wait_idle();

        // Random phases over a range of disk sizes, the extremes among them.
        caps[0] = 40'd1;
        caps[1] = 40'hFF_FFFF_FFFF;
        caps[2] = 40'd1000;
        caps[3] = 40'd64;
        caps[4] = 40'd300;
        caps[5] = {8'($urandom), 32'($urandom)};
        for (int p = 0; p < 8; p++)
        begin
            cap = caps[p % 6];
            throttle = (p != 3);
            write_disk_size(cap);
            push_cmd(FUNC_CLEAR, '0, '0);
            if (p == 2)
                long_hold_req = 1;
            for (int n = 0; n < 240; n++)
                push_random_cmd(cap);
            push_cmd(FUNC_INSERT, 16'($urandom), 40'($urandom_range(0, 7)), 1);
            for (int n = 0; n < 10; n++)
                push_random_cmd(cap);
            wait_idle();
        end

        if (error_count == 0)
            $display("best_fit_segment_allocator_tb: PASS");
        else
            $display("best_fit_segment_allocator_tb: FAIL");
        $finish;
    end

endmodule
